/* src/dda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line stepper package
// Types shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package dda_pkg;

    // Controller states.
    typedef enum logic
    {
        ST_ACCEPT,
        ST_DIVIDE
    } state_t;

    // Item kinds on the input channel.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_NEXT  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic in_ready;
        logic load_line;
        logic step_point;
        logic div_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic in_valid;
        logic in_kind;
        logic n_zero;
        logic out_free;
        logic line_active;
    } status_t;

endpackage

/* src/dda_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line stepper channels
// Valid/ready channels for endpoint words in and point words out.
// ----------------------------------------------------------------------------
interface dda_in_if #(
    parameter int COORD_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_out_if #(
    parameter int COORD_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

/* src/dda_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line stepper controller
// Accepts words, issues load and step commands and sequences the division.
// ----------------------------------------------------------------------------
module dda_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dda_pkg::status_t st,
    output dda_pkg::cmd_t    cmd
);
    import dda_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   div_cnt_reg;
    logic [CNT_W-1:0]   div_cnt_next;
    logic               in_fire;

    // State and division counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ACCEPT;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_fire      = 1'b0;
        case (state_reg)
            ST_ACCEPT:
            begin
                cmd.in_ready = st.out_free;
                in_fire      = st.in_valid && st.out_free;
                if (in_fire)
                begin
                    if (st.in_kind == KIND_START)
                    begin
                        cmd.load_line = 1'b1;
                        div_cnt_next  = '0;
                        if (!st.n_zero)
                        begin
                            state_next = ST_DIVIDE;
                        end
                    end
                    else if (st.line_active)
                    begin
                        cmd.step_point = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                // One quotient bit per cycle on both axes.
                cmd.div_step = 1'b1;
                if (div_cnt_reg == CNT_W'(FRAC_BITS - 1))
                begin
                    state_next = ST_ACCEPT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

`ifndef SYNTHESIS
    // No word is taken while the increments are still being divided out.
    a_no_accept_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> !cmd.in_ready)
        else $error("input accepted during division");

    // A point step only happens on an active line.
    a_step_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_point |-> st.line_active)
        else $error("step issued with no active line");

    // The division counter never runs past the fraction width.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> div_cnt_reg <= CNT_W'(FRAC_BITS - 1))
        else $error("division counter out of range");

    // A line start that needs division always enters the divide state.
    a_load_divides: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_line && !st.n_zero |=> state_reg == ST_DIVIDE)
        else $error("division not started");
`endif

endmodule

/* src/dda_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line stepper datapath
// Endpoint differences, restoring dividers, accumulators and output register.
// ----------------------------------------------------------------------------
module dda_datapath #(
    parameter int COORD_BITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    dda_in_if.sink           line_in,
    dda_out_if.source        point_out,
    input  dda_pkg::cmd_t    cmd,
    output dda_pkg::status_t st
);
    import dda_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int ACC_W = C + F;

    // Line set-up terms from the input word.
    logic         neg_x;
    logic         neg_y;
    logic [C-1:0] mag_x;
    logic [C-1:0] mag_y;
    logic [C-1:0] n_in;

    // Stored line state.
    logic [ACC_W-1:0] acc_x_reg;
    logic [ACC_W-1:0] acc_y_reg;
    logic [ACC_W-1:0] acc_x_next;
    logic [ACC_W-1:0] acc_y_next;
    logic             neg_x_reg;
    logic             neg_y_reg;
    logic [F:0]       q_x_reg;
    logic [F:0]       q_y_reg;
    logic [C-1:0]     rem_x_reg;
    logic [C-1:0]     rem_y_reg;
    logic [C-1:0]     n_reg;
    logic [C-1:0]     steps_left_reg;

    // Divider trial subtraction.
    logic [C+1:0]     trial_x;
    logic [C+1:0]     trial_y;
    logic [C:0]       rem2_x;
    logic [C:0]       rem2_y;

    // Output register.
    logic             out_valid_reg;
    logic [C-1:0]     point_x_reg;
    logic [C-1:0]     point_y_reg;
    logic             last_reg;

    // Absolute differences and step count.
    always_comb
    begin
        neg_x = line_in.end_x < line_in.start_x;
        neg_y = line_in.end_y < line_in.start_y;
        mag_x = neg_x ? (line_in.start_x - line_in.end_x) : (line_in.end_x - line_in.start_x);
        mag_y = neg_y ? (line_in.start_y - line_in.end_y) : (line_in.end_y - line_in.start_y);
        n_in  = (mag_x > mag_y) ? mag_x : mag_y;
    end

    // Trial subtraction of the shifted remainder against the step count.
    always_comb
    begin
        rem2_x  = {rem_x_reg, 1'b0};
        rem2_y  = {rem_y_reg, 1'b0};
        trial_x = {1'b0, rem2_x} - {2'b00, n_reg};
        trial_y = {1'b0, rem2_y} - {2'b00, n_reg};
    end

    // Accumulators move by the signed increment.
    always_comb
    begin
        acc_x_next = neg_x_reg ? (acc_x_reg - ACC_W'(q_x_reg)) : (acc_x_reg + ACC_W'(q_x_reg));
        acc_y_next = neg_y_reg ? (acc_y_reg - ACC_W'(q_y_reg)) : (acc_y_reg + ACC_W'(q_y_reg));
    end

    // Line payload: accumulators, signs and divider registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_line)
        begin
            acc_x_reg <= {line_in.start_x, {F{1'b0}}};
            acc_y_reg <= {line_in.start_y, {F{1'b0}}};
            neg_x_reg <= neg_x;
            neg_y_reg <= neg_y;
            n_reg     <= n_in;
            // The integer bit of the quotient is set only when the axis
            // moves a full unit per step.
            q_x_reg   <= {{F{1'b0}}, (mag_x == n_in)};
            q_y_reg   <= {{F{1'b0}}, (mag_y == n_in)};
            rem_x_reg <= (mag_x == n_in) ? '0 : mag_x;
            rem_y_reg <= (mag_y == n_in) ? '0 : mag_y;
        end
        else if (cmd.div_step)
        begin
            q_x_reg <= {q_x_reg[F-1:0], ~trial_x[C+1]};
            q_y_reg <= {q_y_reg[F-1:0], ~trial_y[C+1]};
            rem_x_reg <= trial_x[C+1] ? rem2_x[C-1:0] : trial_x[C-1:0];
            rem_y_reg <= trial_y[C+1] ? rem2_y[C-1:0] : trial_y[C-1:0];
        end
        else if (cmd.step_point)
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

    // Remaining step count; zero means no line is active.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_left_reg <= '0;
        end
        else if (cmd.load_line)
        begin
            steps_left_reg <= n_in;
        end
        else if (cmd.step_point)
        begin
            steps_left_reg <= steps_left_reg - 1'b1;
        end
    end

    // Output word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_line || cmd.step_point)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (point_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_line)
        begin
            point_x_reg <= line_in.start_x;
            point_y_reg <= line_in.start_y;
            last_reg    <= (n_in == '0);
        end
        else if (cmd.step_point)
        begin
            point_x_reg <= acc_x_next[ACC_W-1:F];
            point_y_reg <= acc_y_next[ACC_W-1:F];
            last_reg    <= (steps_left_reg == C'(1));
        end
    end

    // Ports and status.
    assign line_in.ready        = cmd.in_ready;
    assign point_out.valid      = out_valid_reg;
    assign point_out.point_x    = point_x_reg;
    assign point_out.point_y    = point_y_reg;
    assign point_out.last_point = last_reg;

    assign st.in_valid    = line_in.valid;
    assign st.in_kind     = line_in.kind;
    assign st.n_zero      = (n_in == '0);
    assign st.out_free    = !out_valid_reg || point_out.ready;
    assign st.line_active = (steps_left_reg != '0);

`ifndef SYNTHESIS
    // The last step of a line leaves the block idle.
    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_point && steps_left_reg == C'(1) |=> steps_left_reg == '0)
        else $error("line still active after its last step");

    // The divider remainder stays below the step count.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_x_reg < n_reg && rem_y_reg < n_reg)
        else $error("divider remainder out of range");

    // A point word is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_line || cmd.step_point) |-> (!out_valid_reg || point_out.ready))
        else $error("output word overwritten");
`endif

endmodule

/* src/dda_line_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line stepper
// Steps along a line between endpoints, one point word per start or step.
// ----------------------------------------------------------------------------
//  Channel     Direction  Contents
//  line_in     in         kind, start_x, start_y, end_x, end_y
//  point_out   out        point_x, point_y, last_point
//
//  A start word puts the first point in the output register; unless the line
//  has no steps, the increments are then worked out one quotient bit per
//  cycle in a restoring divider per axis before the next word is taken.
//  Next words, one per cycle unless output stalls, add the increments once.
//  A next word while no line is active is taken and gives no point.
//  rst_n clears the controller, the step count and the output valid flag.
//  A stalled output holds its word and stops further input until taken.
// ----------------------------------------------------------------------------
module dda_line_stepper #(
    parameter int COORD_BITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    dda_in_if.sink    line_in,
    dda_out_if.source point_out
);
    import dda_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Control sequencing.
    dda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // Arithmetic and output register.
    dda_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_in   (line_in),
        .point_out (point_out),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
